>>> sv/assert_macros.svh
// Assertion macros shared by the checker files.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that pre implies post in the following cycle.
`define SWHC_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("swhc: next-cycle check failed");

// Check that pre implies post in the same cycle.
`define SWHC_ASSERT_NOW(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("swhc: same-cycle check failed");

`endif

>>> sv/swhc_pkg.sv
// Shared constants and controller/datapath interface types.
// No dependencies.
package swhc_pkg;

    localparam int WINDOW   = 300;
    localparam int STAMP_W  = 31;
    localparam int CNT_W    = 32;
    localparam int TOTAL_W  = 41;
    localparam int IDX_W    = $clog2(WINDOW);
    localparam int ENTRY_W  = STAMP_W + CNT_W;
    localparam int SUM_W    = (CNT_W + IDX_W > TOTAL_W) ? (CNT_W + IDX_W) : TOTAL_W;

    localparam int RECIP_SHIFT = STAMP_W + IDX_W;
    localparam int RECIP_W     = STAMP_W + 1;
    localparam int PROD_W      = STAMP_W + RECIP_W;
    localparam int QUOT_W      = PROD_W - RECIP_SHIFT;

    localparam logic [IDX_W-1:0]    IDX_LAST   = IDX_W'(WINDOW - 1);
    localparam logic signed [STAMP_W:0] WIN_DIFF = (STAMP_W + 1)'(WINDOW);
    localparam logic [STAMP_W-1:0]  WIN_STAMP  = STAMP_W'(WINDOW);
    localparam logic [RECIP_W-1:0]  RECIP      =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));
    localparam logic [CNT_W-1:0]    CNT_MAX    = '1;
    localparam logic [SUM_W-1:0]    TOTAL_MAX  = SUM_W'({TOTAL_W{1'b1}});

    localparam logic ACT_HIT   = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    typedef struct packed {
        logic load;
        logic clr_wr;
        logic idx_inc;
        logic mod_step;
        logic hit_rd;
        logic hit_wr;
        logic scan_rd;
        logic out_load;
    } swhc_cmd_t;

    typedef struct packed {
        logic idx_last;
        logic mod_last;
        logic out_free;
    } swhc_sts_t;

endpackage

>>> sv/sliding_window_hit_counter_core.sv
// Top level of the bucketed sliding-window hit counter.
// Depends on swhc_pkg, swhc_ctrl and swhc_dp.
//
// Input channel: in_valid / in_stall carry a word of action and timestamp.
// action = 0 records a hit at timestamp, action = 1 asks for the hit total
// over the window of swhc_pkg::WINDOW seconds ending at timestamp.
// Output channel: out_valid / out_stall carry hit_total, one word per query;
// hits give no output word.
// Operation (W = WINDOW = 300): a hit finds its bucket with a reciprocal
// multiply and a subtract, then does one read-modify-write of the bucket
// RAM, and the input then takes the next word. A query scans the W buckets
// through the single RAM port, one per cycle, then loads hit_total into the
// output register, and the input takes the next word in the cycle after the
// result is loaded.
// Reset: a clearing pass writes zero to every bucket, one per cycle;
// in_stall stays high until it finishes.
// A stalled output word holds; a finished query waits for the output
// register to drain before it loads, and the input stays stalled meanwhile.
module sliding_window_hit_counter_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         action,
    input  logic [swhc_pkg::STAMP_W-1:0] timestamp,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [swhc_pkg::TOTAL_W-1:0] hit_total
);

    swhc_pkg::swhc_cmd_t cmd;
    swhc_pkg::swhc_sts_t sts;

    swhc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .action   (action),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    swhc_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .timestamp (timestamp),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .hit_total (hit_total)
    );

endmodule

>>> sv/swhc_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
module swhc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

>>> sv/swhc_ctrl.sv
// Controller for the hit counter: clearing pass, hit update and query scan.
// Depends on swhc_pkg.
module swhc_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                action,
    output logic                in_stall,
    input  swhc_pkg::swhc_sts_t sts,
    output swhc_pkg::swhc_cmd_t cmd
);

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_MOD    = 3'd2;
    localparam logic [2:0] ST_HRD    = 3'd3;
    localparam logic [2:0] ST_HWR    = 3'd4;
    localparam logic [2:0] ST_QSCAN  = 3'd5;
    localparam logic [2:0] ST_QDRAIN = 3'd6;
    localparam logic [2:0] ST_QOUT   = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_wr  = 1'b1;
                cmd.idx_inc = !sts.idx_last;
                if (sts.idx_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = (action == swhc_pkg::ACT_QUERY) ? ST_QSCAN : ST_MOD;
                end
            end
            ST_MOD:
            begin
                cmd.mod_step = 1'b1;
                if (sts.mod_last)
                begin
                    state_next = ST_HRD;
                end
            end
            ST_HRD:
            begin
                cmd.hit_rd = 1'b1;
                state_next = ST_HWR;
            end
            ST_HWR:
            begin
                cmd.hit_wr = 1'b1;
                state_next = ST_IDLE;
            end
            ST_QSCAN:
            begin
                cmd.scan_rd = 1'b1;
                cmd.idx_inc = !sts.idx_last;
                if (sts.idx_last)
                begin
                    state_next = ST_QDRAIN;
                end
            end
            ST_QDRAIN:
            begin
                state_next = ST_QOUT;
            end
            ST_QOUT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> sv/swhc_dp.sv
// Datapath for the hit counter: bucket RAM, modulo unit, scan accumulator, output word.
// Depends on swhc_pkg and swhc_ram.
module swhc_dp (
    input  logic                             clk,
    input  logic                             rst_n,
    input  swhc_pkg::swhc_cmd_t              cmd,
    output swhc_pkg::swhc_sts_t              sts,
    input  logic [swhc_pkg::STAMP_W-1:0]     timestamp,
    input  logic                             out_stall,
    output logic                             out_valid,
    output logic [swhc_pkg::TOTAL_W-1:0]     hit_total
);

    logic [swhc_pkg::STAMP_W-1:0]  t_reg;
    logic                          mod_ph_reg;
    logic                          mod_ph_next;
    logic [swhc_pkg::PROD_W-1:0]   prod;
    logic [swhc_pkg::QUOT_W-1:0]   quot_reg;
    logic [swhc_pkg::QUOT_W-1:0]   quot_next;
    logic [swhc_pkg::STAMP_W-1:0]  rem_full;
    logic [swhc_pkg::IDX_W-1:0]    rem_reg;
    logic [swhc_pkg::IDX_W-1:0]    rem_next;
    logic [swhc_pkg::IDX_W-1:0]    idx_reg;
    logic [swhc_pkg::IDX_W-1:0]    idx_next;
    logic                          scan_q_reg;
    logic [swhc_pkg::SUM_W-1:0]    acc_reg;
    logic [swhc_pkg::SUM_W-1:0]    acc_next;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [swhc_pkg::TOTAL_W-1:0]  total_reg;

    logic                          ram_we;
    logic [swhc_pkg::IDX_W-1:0]    ram_addr;
    logic [swhc_pkg::ENTRY_W-1:0]  ram_wdata;
    logic [swhc_pkg::ENTRY_W-1:0]  ram_rdata;
    logic [swhc_pkg::STAMP_W-1:0]  rd_stamp;
    logic [swhc_pkg::CNT_W-1:0]    rd_count;
    logic [swhc_pkg::CNT_W-1:0]    new_count;
    logic signed [swhc_pkg::STAMP_W:0] diff;

    swhc_ram #(
        .WIDTH (swhc_pkg::ENTRY_W),
        .DEPTH (swhc_pkg::WINDOW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign rd_stamp = ram_rdata[swhc_pkg::ENTRY_W-1:swhc_pkg::CNT_W];
    assign rd_count = ram_rdata[swhc_pkg::CNT_W-1:0];
    assign diff     = $signed({1'b0, t_reg}) - $signed({1'b0, rd_stamp});

    // Quotient by reciprocal multiply in the first step, remainder in the second.
    assign prod     = swhc_pkg::PROD_W'(t_reg) * swhc_pkg::PROD_W'(swhc_pkg::RECIP);
    assign rem_full = t_reg - swhc_pkg::STAMP_W'(quot_reg) * swhc_pkg::WIN_STAMP;

    always_comb
    begin
        mod_ph_next = mod_ph_reg;
        quot_next   = quot_reg;
        rem_next    = rem_reg;
        if (cmd.load)
        begin
            mod_ph_next = 1'b0;
        end
        else if (cmd.mod_step)
        begin
            mod_ph_next = 1'b1;
            if (mod_ph_reg)
            begin
                rem_next = rem_full[swhc_pkg::IDX_W-1:0];
            end
            else
            begin
                quot_next = prod[swhc_pkg::PROD_W-1:swhc_pkg::RECIP_SHIFT];
            end
        end
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.load)
        begin
            idx_next = '0;
        end
        else if (cmd.idx_inc)
        begin
            idx_next = idx_reg + 1'b1;
        end
    end

    always_comb
    begin
        if (rd_stamp == t_reg)
        begin
            new_count = (rd_count == swhc_pkg::CNT_MAX) ? rd_count : rd_count + 1'b1;
        end
        else
        begin
            new_count = swhc_pkg::CNT_W'(1);
        end
    end

    always_comb
    begin
        ram_we    = cmd.clr_wr || cmd.hit_wr;
        ram_addr  = (cmd.hit_rd || cmd.hit_wr) ? rem_reg : idx_reg;
        ram_wdata = cmd.hit_wr ? {t_reg, new_count} : '0;
    end

    always_comb
    begin
        acc_next = acc_reg;
        if (cmd.load)
        begin
            acc_next = '0;
        end
        else if (scan_q_reg && (diff < swhc_pkg::WIN_DIFF))
        begin
            acc_next = acc_reg + swhc_pkg::SUM_W'(rd_count);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            mod_ph_reg    <= 1'b0;
            scan_q_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            mod_ph_reg    <= mod_ph_next;
            scan_q_reg    <= cmd.scan_rd;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            t_reg <= timestamp;
        end
        if (cmd.out_load)
        begin
            total_reg <= (acc_reg > swhc_pkg::TOTAL_MAX) ? '1 :
                         acc_reg[swhc_pkg::TOTAL_W-1:0];
        end
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        acc_reg  <= acc_next;
    end

    assign sts.idx_last = (idx_reg == swhc_pkg::IDX_LAST);
    assign sts.mod_last = mod_ph_reg;
    assign sts.out_free = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign hit_total = total_reg;

endmodule

>>> sv/swhc_checker.sv
// Port-level checks for the hit counter, bound to its top level.
// Depends on swhc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module swhc_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_stall,
    input logic                         action,
    input logic                         out_valid,
    input logic                         out_stall,
    input logic [swhc_pkg::TOTAL_W-1:0] hit_total
);

    `SWHC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
    `SWHC_ASSERT_NEXT(a_total_hold, out_valid && out_stall, $stable(hit_total))
    `SWHC_ASSERT_NEXT(a_busy_after_take, in_valid && !in_stall, in_stall)
    `SWHC_ASSERT_NEXT(a_hit_no_word,
        in_valid && !in_stall && (action == swhc_pkg::ACT_HIT) && !out_valid, !out_valid)

endmodule

bind sliding_window_hit_counter_core swhc_checker u_swhc_checker (.*);
